// File: rtl/ovsf_pkg.sv
package ovsf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_W     = 32 + FRAC_BITS;   // dividend width: step << FRAC_BITS
    localparam int SCALE_W   = 21;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 21;

    localparam logic [SCALE_W-1:0] SCALE_ONE   = SCALE_W'(1 << FRAC_BITS);
    localparam logic [15:0]        EMA_RST     = 16'd3277;
    localparam logic [16:0]        MIN_STEP_RST = 17'(((1 << FRAC_BITS) + 500) / 1000);
    localparam logic [19:0]        RLOW_RST    = 20'(((1 << FRAC_BITS) + 5) / 10);
    localparam logic [20:0]        RHIGH_RST   = 21'(10 << FRAC_BITS);
    localparam logic [20:0]        SPACING_RST = 21'(1 << FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EMA_WEIGHT  = 3'd0,
        CFG_MIN_STEP    = 3'd1,
        CFG_RATIO_LOW   = 3'd2,
        CFG_RATIO_HIGH  = 3'd3,
        CFG_PIN_SPACING = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_SQRT,
        S_DIV_GO,
        S_DIV,
        S_EMA,
        S_PINCHK,
        S_FUSE,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        G_WHEEL,
        G_CAM,
        G_PIN
    } t_group;

    typedef struct packed {
        logic signed [31:0] wheel_x;
        logic signed [31:0] wheel_y;
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
        logic [7:0]         hazard_code;
    } t_in;

    typedef struct packed {
        logic signed [31:0] fused_x;
        logic signed [31:0] fused_y;
        logic [SCALE_W-1:0] scale_now;
        logic               pin_drop;
        logic signed [31:0] pin_x;
        logic signed [31:0] pin_y;
        logic signed [31:0] pin_z;
        logic [7:0]         pin_class;
    } t_out;

    // magnitude of a - b after saturation to signed 32 bit
    function automatic logic [31:0] sat_mag(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] d;
        logic [32:0]        m;
        d = $signed({a[31], a}) - $signed({b[31], b});
        m = d[32] ? 33'(-d) : 33'(d);
        if (d[32])
            return (m > 33'h0_8000_0000) ? 32'h8000_0000 : m[31:0];
        return (m > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    endfunction

    function automatic logic [31:0] abs32(input logic [31:0] p);
        return p[31] ? 32'(-p) : p;
    endfunction

    // |p| * scale product -> signed, truncated toward zero, saturated
    function automatic logic [31:0] fuse_sat(input logic neg, input logic [63:0] prod);
        logic [63:0] q;
        logic [63:0] nq;
        q  = prod >> FRAC_BITS;
        nq = -q;
        if (neg)
            return (q > 64'h8000_0000) ? 32'h8000_0000 : nq[31:0];
        return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

endpackage

// File: rtl/ovsf_isqrt.sv
module ovsf_isqrt
    import ovsf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [63:0] r_rad;
    logic [33:0] r_rem;
    logic [31:0] r_root;

    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        take;

    // one result bit per cycle, restoring
    assign rem_sh = {r_rem, r_rad[63:62]};
    assign trial  = {2'b00, r_root, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[61:0], 2'b00};
            r_rem  <= take ? 34'(rem_sh - trial) : rem_sh[33:0];
            r_root <= {r_root[30:0], take};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: rtl/ovsf_div.sv
module ovsf_div
    import ovsf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [31:0]      i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [31:0]      r_rem;
    logic [31:0]      r_den;

    logic [32:0] rem_sh;
    logic        take;

    // dividend shifts out of r_q as quotient bits shift in
    assign rem_sh = {r_rem, r_q[NUM_W-1]};
    assign take   = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= take ? 32'(rem_sh - {1'b0, r_den}) : rem_sh[31:0];
            r_q   <= {r_q[NUM_W-2:0], take};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// File: rtl/odometry_visual_scale_fusion.sv
// Wheel / camera scale fusion with hazard pin placement.
//
// Input channel (i_in_valid / o_in_ready / i_in_data): one beat per camera
// frame with wheel x,y, camera x,y,z and a hazard code. The first beat after
// reset only latches the previous positions and yields no output beat.
// Output channel (o_out_valid / i_out_ready / o_out_data): one beat per later
// input beat with fused x,y, the current scale and an optional hazard pin.
// Config port (i_cfg_we / i_cfg_idx / i_cfg_data): single-cycle register
// writes, only while the block is idle: a user rule the block does not enforce.
//
// One item at a time; cost is set by the shared sequential units: a square
// root unit (run twice, three times with a hazard), a divider (only when
// both steps clear min_step) and one registered 32x32 multiplier for
// squares, the moving average and the fused products. o_in_ready is high
// only in idle. Reset (synchronous, active low) restores register defaults,
// scale 1.0 and zero history. A stalled receiver holds the finished beat in
// the output register; the block may take the next input meanwhile but
// parks before writing its own result until the slot frees.
module odometry_visual_scale_fusion
    import ovsf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // config
    logic [15:0] r_ema_weight;
    logic [16:0] r_min_step;
    logic [19:0] r_ratio_low;
    logic [20:0] r_ratio_high;
    logic [20:0] r_pin_spacing;

    // sequencer
    t_state r_state, n_state;
    t_group r_group;
    logic [1:0] r_k;

    // history
    logic               r_first;
    logic [31:0]        r_prev_wx, r_prev_wy, r_prev_cx, r_prev_cz;
    logic [SCALE_W-1:0] r_scale;
    logic [31:0]        r_last_px, r_last_py, r_last_pz;

    // working
    t_in              r_in;
    logic [63:0]      r_prod;
    logic [63:0]      r_acc;
    logic [31:0]      r_dw, r_ds;
    logic [NUM_W-1:0] r_ratio;
    logic             r_drop;
    logic [31:0]      r_fx, r_fy;
    t_out             r_out;
    logic             r_out_valid;

    // unit controls
    logic             sq_start, sq_done;
    logic [63:0]      sq_radicand;
    logic [31:0]      sq_root;
    logic             div_start, div_done;
    logic [NUM_W-1:0] div_quot;
    logic [31:0]      mul_a, mul_b;

    logic       in_acc;
    logic       slot_free;
    logic [1:0] sq_last;
    logic       step_ok;
    logic       ratio_ok;
    logic       at_zero;
    logic       pin_hit;

    assign in_acc    = i_in_valid && o_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;
    assign sq_last   = (r_group == G_PIN) ? 2'd3 : 2'd2;
    assign step_ok   = (sq_root > 32'(r_min_step)) && (r_dw > 32'(r_min_step));
    assign ratio_ok  = (div_quot > NUM_W'(r_ratio_low)) && (div_quot < NUM_W'(r_ratio_high));
    assign at_zero   = (r_last_px == '0) && (r_last_py == '0) && (r_last_pz == '0);
    assign pin_hit   = (sq_root > 32'(r_pin_spacing)) || at_zero;

    ovsf_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sq_start),
        .i_radicand (sq_radicand),
        .o_done     (sq_done),
        .o_root     (sq_root)
    );

    ovsf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({r_dw, {FRAC_BITS{1'b0}}}),
        .i_den   (r_ds),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && !r_first) n_state = S_SQ;
            end
            S_SQ: begin
                if (r_k == sq_last) n_state = S_SQRT;
            end
            S_SQRT: begin
                if (sq_done) begin
                    case (r_group)
                        G_WHEEL: n_state = S_SQ;
                        G_CAM:   n_state = step_ok ? S_DIV_GO : S_PINCHK;
                        default: n_state = S_FUSE;
                    endcase
                end
            end
            S_DIV_GO: n_state = S_DIV;
            S_DIV: begin
                if (div_done) n_state = ratio_ok ? S_EMA : S_PINCHK;
            end
            S_EMA: begin
                if (r_k == 2'd2) n_state = S_PINCHK;
            end
            S_PINCHK: n_state = (r_in.hazard_code != '0) ? S_SQ : S_FUSE;
            S_FUSE: begin
                if (r_k == 2'd2) n_state = S_OUT;
            end
            S_OUT: begin
                if (slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs and shared multiplier operands
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        sq_start    = (r_state == S_SQ) && (r_k == sq_last);
        sq_radicand = r_acc + r_prod;
        div_start   = (r_state == S_DIV_GO);
        mul_a       = '0;
        mul_b       = '0;
        case (r_state)
            S_SQ: begin
                case (r_group)
                    G_WHEEL: mul_a = (r_k == 2'd0) ? sat_mag(r_in.wheel_x, r_prev_wx)
                                                   : sat_mag(r_in.wheel_y, r_prev_wy);
                    G_CAM:   mul_a = (r_k == 2'd0) ? sat_mag(r_in.cam_x, r_prev_cx)
                                                   : sat_mag(r_in.cam_z, r_prev_cz);
                    default: begin
                        case (r_k)
                            2'd0:    mul_a = sat_mag(r_in.cam_x, r_last_px);
                            2'd1:    mul_a = sat_mag(r_in.cam_y, r_last_py);
                            default: mul_a = sat_mag(r_in.cam_z, r_last_pz);
                        endcase
                    end
                endcase
                mul_b = mul_a;
            end
            S_EMA: begin
                if (r_k == 2'd0) begin
                    mul_a = 32'(r_ema_weight);
                    mul_b = 32'(r_ratio[SCALE_W-1:0]);
                end else begin
                    mul_a = 32'(17'h1_0000 - 17'(r_ema_weight));
                    mul_b = 32'(r_scale);
                end
            end
            S_FUSE: begin
                mul_a = (r_k == 2'd0) ? abs32(r_in.cam_x) : abs32(r_in.cam_z);
                mul_b = 32'(r_scale);
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_k           <= '0;
            r_group       <= G_WHEEL;
            r_first       <= 1'b1;
            r_out_valid   <= 1'b0;
            r_ema_weight  <= EMA_RST;
            r_min_step    <= MIN_STEP_RST;
            r_ratio_low   <= RLOW_RST;
            r_ratio_high  <= RHIGH_RST;
            r_pin_spacing <= SPACING_RST;
            r_scale       <= SCALE_ONE;
            r_prev_wx     <= '0;
            r_prev_wy     <= '0;
            r_prev_cx     <= '0;
            r_prev_cz     <= '0;
            r_last_px     <= '0;
            r_last_py     <= '0;
            r_last_pz     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= (n_state != r_state) ? 2'd0 : r_k + 2'd1;

            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_EMA_WEIGHT:  r_ema_weight  <= i_cfg_data[15:0];
                    CFG_MIN_STEP:    r_min_step    <= i_cfg_data[16:0];
                    CFG_RATIO_LOW:   r_ratio_low   <= i_cfg_data[19:0];
                    CFG_RATIO_HIGH:  r_ratio_high  <= i_cfg_data[20:0];
                    CFG_PIN_SPACING: r_pin_spacing <= i_cfg_data[20:0];
                    default: ;
                endcase
            end

            if (r_state == S_IDLE && in_acc) begin
                r_group <= G_WHEEL;
                if (r_first) begin
                    // first beat only seeds the history
                    r_first   <= 1'b0;
                    r_prev_wx <= i_in_data.wheel_x;
                    r_prev_wy <= i_in_data.wheel_y;
                    r_prev_cx <= i_in_data.cam_x;
                    r_prev_cz <= i_in_data.cam_z;
                end
            end
            if (r_state == S_SQRT && sq_done && r_group == G_WHEEL) r_group <= G_CAM;
            if (r_state == S_PINCHK) r_group <= G_PIN;

            if (r_state == S_EMA && r_k == 2'd2)
                r_scale <= SCALE_W'((r_acc + r_prod) >> 16);

            if (r_state == S_SQRT && sq_done && r_group == G_PIN && pin_hit) begin
                r_last_px <= r_in.cam_x;
                r_last_py <= r_in.cam_y;
                r_last_pz <= r_in.cam_z;
            end

            if (r_state == S_OUT && slot_free) begin
                r_out_valid <= 1'b1;
                r_prev_wx   <= r_in.wheel_x;
                r_prev_wy   <= r_in.wheel_y;
                r_prev_cx   <= r_in.cam_x;
                r_prev_cz   <= r_in.cam_z;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);

        if (r_state == S_IDLE && in_acc) begin
            r_in   <= i_in_data;
            r_drop <= 1'b0;
        end

        if (r_state == S_SQ || r_state == S_EMA)
            r_acc <= (r_k == 2'd0) ? 64'd0 : r_acc + r_prod;

        if (r_state == S_SQRT && sq_done) begin
            case (r_group)
                G_WHEEL: r_dw <= sq_root;
                G_CAM:   r_ds <= sq_root;
                default: r_drop <= pin_hit;
            endcase
        end

        if (r_state == S_DIV && div_done) r_ratio <= div_quot;

        if (r_state == S_FUSE && r_k == 2'd1) r_fx <= fuse_sat(r_in.cam_x[31], r_prod);
        if (r_state == S_FUSE && r_k == 2'd2) r_fy <= fuse_sat(r_in.cam_z[31], r_prod);

        if (r_state == S_OUT && slot_free) begin
            r_out.fused_x   <= r_fx;
            r_out.fused_y   <= r_fy;
            r_out.scale_now <= r_scale;
            r_out.pin_drop  <= r_drop;
            r_out.pin_x     <= r_drop ? r_in.cam_x : '0;
            r_out.pin_y     <= r_drop ? r_in.cam_y : '0;
            r_out.pin_z     <= r_drop ? r_in.cam_z : '0;
            r_out.pin_class <= r_drop ? r_in.hazard_code : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: rtl/ovsf_checker.sv
module ovsf_checker
    import ovsf_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input t_in                  i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input t_out                 o_out_data,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_idx,
    input logic [CFG_W-1:0]     i_cfg_data
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat changed under stall");

    // offered input beat holds until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("input beat changed under stall");

    // register writes only while idle, with known index and data
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> o_in_ready && !$isunknown({i_cfg_idx, i_cfg_data}))
        else $error("register write while busy");

    // scale moves only toward a ratio of at least one lsb
    a_scale_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.scale_now != '0)
        else $error("scale collapsed to zero");

    // pin fields are zero without a drop, and a drop carries a hazard class
    a_pin_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.pin_drop ? (o_out_data.pin_class != '0)
                         : (o_out_data.pin_class == '0 && o_out_data.pin_x == '0 &&
                            o_out_data.pin_y == '0 && o_out_data.pin_z == '0)))
        else $error("pin fields inconsistent");

endmodule

bind odometry_visual_scale_fusion ovsf_checker u_ovsf_checker (.*);

// File: verif/testbench.sv
module testbench;
    import ovsf_pkg::*;

    localparam int DRAIN_CYCLES = 250;   // worst item latency plus margin
    localparam int STALL_LIMIT  = 5000;  // cycles with no beat on any channel
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 in_valid;
    logic                 o_in_ready;
    t_in                  in_data;
    logic                 o_out_valid;
    logic                 out_ready;
    t_out                 o_out_data;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    odometry_visual_scale_fusion u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Shadow copy of the block: registers and frame history
    // ---------------------------------------------------------------
    logic [15:0]        sh_ema;
    logic [16:0]        sh_min_step;
    logic [19:0]        sh_rlow;
    logic [20:0]        sh_rhigh;
    logic [20:0]        sh_spacing;
    logic               sh_first;
    logic signed [31:0] sh_pwx, sh_pwy, sh_pcx, sh_pcz;
    logic [20:0]        sh_scale;
    logic signed [31:0] sh_lpx, sh_lpy, sh_lpz;

    t_in  frame_queue[$];     // beats waiting for the driver
    t_out fused_expect[$];    // predicted output beats, oldest first
    int   errors;
    bit   calm;               // no idling on either side
    int   hold_left;          // receiver hold-off counter
    int   send_gap;
    int   recv_gap;
    int   quiet_cycles;

    // squared magnitude of a - b, difference saturated to signed 32 bit
    function automatic logic [63:0] sq_sat_diff(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        longint d;
        logic [63:0] m;
        d = longint'(a) - longint'(b);
        if (d > 64'sd2147483647) d = 64'sd2147483647;
        if (d < -64'sd2147483648) d = -64'sd2147483648;
        m = (d < 0) ? 64'(-d) : 64'(d);
        return m * m;
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // |p| * s >> FRAC_BITS toward zero, sign restored, saturated
    function automatic logic [31:0] scaled_pos(input logic signed [31:0] p,
                                               input logic [20:0] s);
        logic [63:0] m;
        logic [63:0] q;
        m = (p < 0) ? 64'(-longint'(p)) : 64'(p);
        q = (m * 64'(s)) >> FRAC_BITS;
        if (p < 0) return (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
        return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

    task automatic predict_fusion(input t_in f);
        logic [63:0] dw, ds, ratio, acc, d3;
        t_out r;
        if (sh_first) begin
            // opening frame only latches history
            sh_first = 1'b0;
        end else begin
            dw = int_sqrt(sq_sat_diff(f.wheel_x, sh_pwx) + sq_sat_diff(f.wheel_y, sh_pwy));
            ds = int_sqrt(sq_sat_diff(f.cam_x, sh_pcx) + sq_sat_diff(f.cam_z, sh_pcz));
            if (ds > sh_min_step && dw > sh_min_step && ds != 0) begin
                ratio = (dw << FRAC_BITS) / ds;
                if (ratio > sh_rlow && ratio < sh_rhigh) begin
                    acc = 64'(sh_ema) * ratio + 64'(17'd65536 - sh_ema) * 64'(sh_scale);
                    sh_scale = acc[36:16];
                end
            end
            r = '0;
            if (f.hazard_code != 0) begin
                d3 = int_sqrt(sq_sat_diff(f.cam_x, sh_lpx) + sq_sat_diff(f.cam_y, sh_lpy)
                              + sq_sat_diff(f.cam_z, sh_lpz));
                // drop when far enough, or when no pin was ever set
                if (d3 > sh_spacing || (sh_lpx == 0 && sh_lpy == 0 && sh_lpz == 0)) begin
                    r.pin_drop  = 1'b1;
                    r.pin_x     = f.cam_x;
                    r.pin_y     = f.cam_y;
                    r.pin_z     = f.cam_z;
                    r.pin_class = f.hazard_code;
                    sh_lpx = f.cam_x;
                    sh_lpy = f.cam_y;
                    sh_lpz = f.cam_z;
                end
            end
            r.fused_x   = scaled_pos(f.cam_x, sh_scale);
            r.fused_y   = scaled_pos(f.cam_z, sh_scale);
            r.scale_now = sh_scale;
            fused_expect = {fused_expect, r};
        end
        sh_pwx = f.wheel_x;
        sh_pwy = f.wheel_y;
        sh_pcx = f.cam_x;
        sh_pcz = f.cam_z;
    endtask

    task automatic report(input string field, input logic [63:0] got,
                          input logic [63:0] want);
        $display("mismatch %s: got %h want %h", field, got, want);
        errors++;
    endtask

    // ---------------------------------------------------------------
    // Input driver: pops frames, holds each beat until accepted
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_valid && o_in_ready) predict_fusion(in_data);
            // slot is free when nothing is offered or the beat just went
            if (!in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (frame_queue.size() > 0) begin
                    in_data  <= frame_queue.pop_front();
                    in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 7);
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold-off on request
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
        end else if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (recv_gap > 0) begin
            out_ready <= 1'b0;
            recv_gap  <= recv_gap - 1;
        end else begin
            out_ready <= 1'b1;
            if (!calm && $urandom_range(0, 4) == 0) recv_gap <= $urandom_range(1, 7);
        end
    end

    // output monitor: each beat against the oldest prediction
    always @(posedge i_clk) begin
        t_out w;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (fused_expect.size() == 0) begin
                report("unexpected beat", 64'(o_out_data.fused_x), 64'd0);
            end else begin
                w = fused_expect.pop_front();
                if (o_out_data.fused_x !== w.fused_x)
                    report("fused_x", o_out_data.fused_x, w.fused_x);
                if (o_out_data.fused_y !== w.fused_y)
                    report("fused_y", o_out_data.fused_y, w.fused_y);
                if (o_out_data.scale_now !== w.scale_now)
                    report("scale_now", o_out_data.scale_now, w.scale_now);
                if (o_out_data.pin_drop !== w.pin_drop)
                    report("pin_drop", o_out_data.pin_drop, w.pin_drop);
                if (o_out_data.pin_x !== w.pin_x) report("pin_x", o_out_data.pin_x, w.pin_x);
                if (o_out_data.pin_y !== w.pin_y) report("pin_y", o_out_data.pin_y, w.pin_y);
                if (o_out_data.pin_z !== w.pin_z) report("pin_z", o_out_data.pin_z, w.pin_z);
                if (o_out_data.pin_class !== w.pin_class)
                    report("pin_class", o_out_data.pin_class, w.pin_class);
            end
        end
    end

    // watchdog: too long with no beat on either channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > STALL_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequencing helpers
    // ---------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_EMA_WEIGHT:  sh_ema      = val[15:0];
            CFG_MIN_STEP:    sh_min_step = val[16:0];
            CFG_RATIO_LOW:   sh_rlow     = val[19:0];
            CFG_RATIO_HIGH:  sh_rhigh    = val[20:0];
            CFG_PIN_SPACING: sh_spacing  = val[20:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [CFG_W-1:0] ema, input logic [CFG_W-1:0] mstep,
                             input logic [CFG_W-1:0] rlo, input logic [CFG_W-1:0] rhi,
                             input logic [CFG_W-1:0] spc);
        write_reg(CFG_EMA_WEIGHT, ema);
        write_reg(CFG_MIN_STEP, mstep);
        write_reg(CFG_RATIO_LOW, rlo);
        write_reg(CFG_RATIO_HIGH, rhi);
        write_reg(CFG_PIN_SPACING, spc);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // wait until every frame went in and every prediction came out
    task automatic drain();
        while (frame_queue.size() > 0 || in_valid || fused_expect.size() > 0 || hold_left > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_in frame(input logic [31:0] wx, input logic [31:0] wy,
                                  input logic [31:0] cx, input logic [31:0] cy,
                                  input logic [31:0] cz, input logic [7:0] hz);
        t_in f;
        f.wheel_x = wx; f.wheel_y = wy;
        f.cam_x = cx; f.cam_y = cy; f.cam_z = cz;
        f.hazard_code = hz;
        return f;
    endfunction

    // append one frame to the driver queue
    task automatic queue_frame(input t_in f);
        frame_queue = {frame_queue, f};
    endtask

    logic signed [31:0] gwx, gwy, gcx, gcy, gcz;

    function automatic logic signed [31:0] nudge();
        int unsigned span;
        span = 1 << $urandom_range(4, 19);
        return $signed($urandom_range(0, 2 * span)) - $signed(span);
    endfunction

    // mostly smooth trajectories so the ratio window is hit; some noise
    task automatic push_random(input int count);
        logic [7:0] hz;
        for (int k = 0; k < count; k++) begin
            hz = ($urandom_range(0, 9) < 4) ? 8'($urandom_range(1, 255)) : 8'd0;
            if ($urandom_range(0, 4) == 0) begin
                gwx = $urandom; gwy = $urandom;
                gcx = $urandom; gcy = $urandom; gcz = $urandom;
            end else begin
                gwx += nudge(); gwy += nudge();
                gcx += nudge(); gcy += nudge(); gcz += nudge();
            end
            queue_frame(frame(gwx, gwy, gcx, gcy, gcz, hz));
        end
    endtask

    // ---------------------------------------------------------------
    // Test flow
    // ---------------------------------------------------------------
    initial begin
        errors = 0; calm = 0; hold_left = 0; quiet_cycles = 0;
        in_valid = 0; in_data = '0; out_ready = 0;
        cfg_we = 0; cfg_idx = CFG_EMA_WEIGHT; cfg_data = '0;
        sh_ema = EMA_RST; sh_min_step = MIN_STEP_RST; sh_rlow = RLOW_RST;
        sh_rhigh = RHIGH_RST; sh_spacing = SPACING_RST;
        sh_first = 1; sh_pwx = 0; sh_pwy = 0; sh_pcx = 0; sh_pcz = 0;
        sh_scale = SCALE_ONE; sh_lpx = 0; sh_lpy = 0; sh_lpz = 0;
        gwx = 0; gwy = 0; gcx = 0; gcy = 0; gcz = 0;
        i_rst_n = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // directed frames under reset defaults
        queue_frame(frame(32'd1000, 32'd2000, 32'd0, 32'd0, 32'd0, 8'hFF)); // latch only
        queue_frame(frame(32'd1000, 32'd2000, 32'd0, 32'd0, 32'd0, 8'd0));  // no motion
        queue_frame(frame(32'h0001_0000, 32'd2000, 32'h0000_8000, 32'd5,
                          32'h0000_8000, 8'd3));                           // ratio, pin
        queue_frame(frame(32'h0002_0000, 32'd2000, 32'h0001_0000, 32'd5,
                          32'h0001_0000, 8'd7));                           // pin too close
        queue_frame(frame(32'h0004_0000, 32'd2000, 32'h0003_0000, 32'h0002_0000,
                          32'h0003_0000, 8'd1));                           // pin far
        queue_frame(frame(32'h0004_0010, 32'd2000, 32'h0003_0010, 32'd0,
                          32'h0003_0000, 8'd0));                           // below min_step
        queue_frame(frame(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 8'hFF));
        queue_frame(frame(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 8'h80));                          // saturated diffs
        queue_frame(frame(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 8'h01));
        queue_frame(frame(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                          32'h0000_0000, 8'h55));
        queue_frame(frame(32'h0010_0000, 32'd0, 32'h0000_1000, 32'd0,
                          32'd0, 8'd0));                                   // ratio too high
        queue_frame(frame(32'h0010_0100, 32'd0, 32'h0010_1000, 32'd0,
                          32'd0, 8'd0));                                   // ratio too low
        queue_frame(frame(32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFE_0000, 32'hFFFF_0000,
                          32'hFFFE_0000, 8'hAA));                          // negatives
        drain();

        // extreme registers, hold off receiver so the block backs up
        write_all(21'd65535, 21'd0, 21'd0, 21'd1048576, 21'd0);
        hold_left <= HOLD_CYCLES;
        push_random(100);
        drain();

        // opposite extremes: nothing updates, pins need huge spacing
        write_all(21'd0, 21'd65536, 21'd655360, 21'd0, 21'd1048576);
        push_random(80);
        drain();

        // mid settings, plus a write to an unmapped index
        write_reg(CFG_UNUSED_IDX, 21'h1F_FFFF);
        write_all(21'($urandom_range(1000, 60000)), 21'($urandom_range(0, 200)),
                  21'($urandom_range(0, 30000)), 21'($urandom_range(200000, 1048576)),
                  21'($urandom_range(0, 300000)));
        push_random(100);
        drain();

        // back to defaults, last stretch without idling
        write_all(21'(EMA_RST), 21'(MIN_STEP_RST), 21'(RLOW_RST), 21'(RHIGH_RST),
                  21'(SPACING_RST));
        calm = 1;
        push_random(120);
        drain();

        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: odometry_visual_scale_fusion.f
rtl/ovsf_pkg.sv
rtl/ovsf_isqrt.sv
rtl/ovsf_div.sv
rtl/odometry_visual_scale_fusion.sv
rtl/ovsf_checker.sv
verif/testbench.sv
